[rtl/stc_pkg.sv]
// ============================================================================
// stc_pkg
// Shared constants and the CORDIC arctangent table for the structure tensor
// feature block.
// ============================================================================
`default_nettype none

package stc_pkg;

    // CORDIC datapath width and number of micro-rotations
    localparam int CORDIC_W     = 64;
    localparam int CORDIC_STEPS = 32;
    localparam int TURN_W       = 32;
    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    // arctan(2^-i) as a fraction of a full turn
    function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
        logic [TURN_W-1:0] val;
        begin
            unique case (idx)
                5'd0:  val = 32'd536870912;
                5'd1:  val = 32'd316933406;
                5'd2:  val = 32'd167458907;
                5'd3:  val = 32'd85004756;
                5'd4:  val = 32'd42667331;
                5'd5:  val = 32'd21354465;
                5'd6:  val = 32'd10679838;
                5'd7:  val = 32'd5340245;
                5'd8:  val = 32'd2670163;
                5'd9:  val = 32'd1335087;
                5'd10: val = 32'd667544;
                5'd11: val = 32'd333772;
                5'd12: val = 32'd166886;
                5'd13: val = 32'd83443;
                5'd14: val = 32'd41722;
                5'd15: val = 32'd20861;
                5'd16: val = 32'd10430;
                5'd17: val = 32'd5215;
                5'd18: val = 32'd2608;
                5'd19: val = 32'd1304;
                5'd20: val = 32'd652;
                5'd21: val = 32'd326;
                5'd22: val = 32'd163;
                5'd23: val = 32'd81;
                5'd24: val = 32'd41;
                5'd25: val = 32'd20;
                5'd26: val = 32'd10;
                5'd27: val = 32'd5;
                5'd28: val = 32'd3;
                5'd29: val = 32'd1;
                5'd30: val = 32'd1;
                default: val = 32'd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/stc_tensor_if.sv]
// ============================================================================
// stc_tensor_if
// Valid/ready channel carrying the three tensor terms of one pixel.
// ============================================================================
`default_nettype none

interface stc_tensor_if #(
    parameter int TENSOR_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic [TENSOR_BITS-1:0]        tensor_xx;
    logic [TENSOR_BITS-1:0]        tensor_yy;
    logic signed [TENSOR_BITS-1:0] tensor_xy;

    modport source (output valid, tensor_xx, tensor_yy, tensor_xy, input ready);
    modport sink   (input valid, tensor_xx, tensor_yy, tensor_xy, output ready);
endinterface

`default_nettype wire

[rtl/stc_feature_if.sv]
// ============================================================================
// stc_feature_if
// Valid/ready channel carrying energy, orientation and coherency of a pixel.
// ============================================================================
`default_nettype none

interface stc_feature_if #(
    parameter int TENSOR_BITS = 24,
    parameter int ANGLE_BITS  = 16,
    parameter int RATIO_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic [TENSOR_BITS:0]   energy;
    logic [ANGLE_BITS-1:0]  orientation;
    logic [RATIO_BITS-1:0]  coherency;

    modport source (output valid, energy, orientation, coherency, input ready);
    modport sink   (input valid, energy, orientation, coherency, output ready);
endinterface

`default_nettype wire

[rtl/structure_tensor_features.sv]
// ============================================================================
// structure_tensor_features
// Energy, orientation and coherency of one pixel's structure tensor.
// ============================================================================
// Usage:
//   tensor  (sink):   one pixel per item: tensor_xx, tensor_yy (unsigned) and
//                     tensor_xy (signed), all with 8 fraction bits.
//   feature (source): one item per pixel, in order: energy = xx + yy,
//                     orientation as a fraction of pi, coherency in Q0.R.
// Throughput: one item per clock cycle while the receiver takes results.
// Pipeline: one set-up stage, 32 CORDIC cells, two squaring stages,
//   TENSOR_BITS + 1 square-root cells, RATIO_BITS divider cells and the
//   output register.
// Stall: when a result waits in the output register and feature.ready is
//   low, the whole chain holds and tensor.ready drops; nothing is lost.
// Reset: rst_n clears all valid bits at once; the chain is empty and ready
//   to take an item as soon as reset is released.
// ============================================================================
`default_nettype none

module structure_tensor_features #(
    parameter int TENSOR_BITS = 24,
    parameter int ANGLE_BITS  = 16,
    parameter int RATIO_BITS  = 16
) (
    input  wire  clk,
    input  wire  rst_n,
    stc_tensor_if.sink    tensor,
    stc_feature_if.source feature
);
    import stc_pkg::*;

    localparam int T     = TENSOR_BITS;
    localparam int RB    = T + 1;
    localparam int RW    = 2 * RB;
    localparam int H     = (T + 2) / 2;
    localparam int SQW   = 4 * H + 2;
    localparam int SIDEC = 3 * T + 4;
    localparam int SIDES = T + 1 + ANGLE_BITS;
    localparam int SIDED = ANGLE_BITS + 2;

    logic en;

    // ---------------------------------------------------------------- set-up
    logic signed [T:0]          diff;
    logic        [T:0]          energy_w;
    logic        [T:0]          adiff_w;
    logic signed [T:0]          xy_ext;
    logic        [T:0]          axy_w;
    logic        [T:0]          across_w;
    logic signed [CORDIC_W-1:0] x0;
    logic signed [CORDIC_W-1:0] y0;

    always_comb
    begin
        diff     = $signed({1'b0, tensor.tensor_xx}) - $signed({1'b0, tensor.tensor_yy});
        energy_w = {1'b0, tensor.tensor_xx} + {1'b0, tensor.tensor_yy};
        adiff_w  = diff[T] ? (T+1)'(-diff) : diff;
        xy_ext   = {tensor.tensor_xy[T-1], tensor.tensor_xy};
        axy_w    = xy_ext[T] ? (T+1)'(-xy_ext) : xy_ext;
        across_w = {axy_w[T-1:0], 1'b0};
        x0       = CORDIC_W'(diff) <<< (58 - T);
        y0       = CORDIC_W'(xy_ext) <<< (59 - T);
    end

    logic                       pre_vld_reg;
    logic signed [CORDIC_W-1:0] pre_x_reg;
    logic signed [CORDIC_W-1:0] pre_y_reg;
    logic        [TURN_W-1:0]   pre_z_reg;
    logic        [SIDEC-1:0]    pre_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_vld_reg <= 1'b0;
        else if (en)
            pre_vld_reg <= tensor.valid;
    end

    // pre-rotate by a half turn when x is negative
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_x_reg    <= diff[T] ? -x0 : x0;
            pre_y_reg    <= diff[T] ? -y0 : y0;
            pre_z_reg    <= diff[T] ? HALF_TURN : '0;
            pre_side_reg <= {energy_w, adiff_w[T-1:0], across_w,
                             (tensor.tensor_xy == '0), diff[T]};
        end
    end

    // ---------------------------------------------------------- CORDIC chain
    logic                       c_vld  [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_x    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_y    [0:CORDIC_STEPS];
    logic        [TURN_W-1:0]   c_z    [0:CORDIC_STEPS];
    logic        [SIDEC-1:0]    c_side [0:CORDIC_STEPS];

    assign c_vld[0]  = pre_vld_reg;
    assign c_x[0]    = pre_x_reg;
    assign c_y[0]    = pre_y_reg;
    assign c_z[0]    = pre_z_reg;
    assign c_side[0] = pre_side_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        stc_cordic_cell #(
            .SHIFT  (i),
            .SIDE_W (SIDEC)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (c_vld[i]),
            .x_in     (c_x[i]),
            .y_in     (c_y[i]),
            .z_in     (c_z[i]),
            .side_in  (c_side[i]),
            .out_vld  (c_vld[i+1]),
            .x_out    (c_x[i+1]),
            .y_out    (c_y[i+1]),
            .z_out    (c_z[i+1]),
            .side_out (c_side[i+1])
        );
    end

    // ------------------------------------------------ angle and squaring
    logic [T:0]          cs_energy;
    logic [T-1:0]        cs_adiff;
    logic [T:0]          cs_across;
    logic                cs_axis;
    logic                cs_xneg;
    logic [TURN_W-1:0]   turn;
    logic [TURN_W-1:0]   turn_rnd;
    logic [2*H-1:0]      d_ext;
    logic [2*H-1:0]      c_ext;

    always_comb
    begin
        {cs_energy, cs_adiff, cs_across, cs_axis, cs_xneg} = c_side[CORDIC_STEPS];
        if (cs_axis)
            turn = cs_xneg ? HALF_TURN : '0;
        else
            turn = c_z[CORDIC_STEPS];
        turn_rnd = turn + (TURN_W'(1) << (31 - ANGLE_BITS));
        d_ext    = (2*H)'(cs_adiff);
        c_ext    = (2*H)'(cs_across);
    end

    logic                  sqa_vld_reg;
    logic [2*H-1:0]        d_hh_reg, d_hl_reg, d_ll_reg;
    logic [2*H-1:0]        c_hh_reg, c_hl_reg, c_ll_reg;
    logic [T:0]            sqa_energy_reg;
    logic [ANGLE_BITS-1:0] sqa_orient_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqa_vld_reg <= 1'b0;
        else if (en)
            sqa_vld_reg <= c_vld[CORDIC_STEPS];
    end

    // split each square into half-width partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_hh_reg       <= d_ext[2*H-1:H] * d_ext[2*H-1:H];
            d_hl_reg       <= d_ext[2*H-1:H] * d_ext[H-1:0];
            d_ll_reg       <= d_ext[H-1:0]   * d_ext[H-1:0];
            c_hh_reg       <= c_ext[2*H-1:H] * c_ext[2*H-1:H];
            c_hl_reg       <= c_ext[2*H-1:H] * c_ext[H-1:0];
            c_ll_reg       <= c_ext[H-1:0]   * c_ext[H-1:0];
            sqa_energy_reg <= cs_energy;
            sqa_orient_reg <= turn_rnd[TURN_W-1 -: ANGLE_BITS];
        end
    end

    logic [SQW-1:0] sq_sum;

    always_comb
    begin
        sq_sum = (SQW'(d_hh_reg) << (2*H)) + (SQW'(d_hl_reg) << (H+1)) + SQW'(d_ll_reg)
               + (SQW'(c_hh_reg) << (2*H)) + (SQW'(c_hl_reg) << (H+1)) + SQW'(c_ll_reg);
    end

    logic                  sqb_vld_reg;
    logic [RW-1:0]         sqb_rad_reg;
    logic [SIDES-1:0]      sqb_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqb_vld_reg <= 1'b0;
        else if (en)
            sqb_vld_reg <= sqa_vld_reg;
    end

    // sum the partial products into the radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqb_rad_reg  <= sq_sum[RW-1:0];
            sqb_side_reg <= {sqa_energy_reg, sqa_orient_reg};
        end
    end

    // ----------------------------------------------------- square-root chain
    logic             s_vld  [0:RB];
    logic [RW-1:0]    s_rad  [0:RB];
    logic [RB+1:0]    s_rem  [0:RB];
    logic [RB-1:0]    s_root [0:RB];
    logic [SIDES-1:0] s_side [0:RB];

    assign s_vld[0]  = sqb_vld_reg;
    assign s_rad[0]  = sqb_rad_reg;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = sqb_side_reg;

    for (genvar i = 0; i < RB; i++)
    begin : g_sqrt
        stc_sqrt_cell #(
            .RB     (RB),
            .RW     (RW),
            .SIDE_W (SIDES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (s_vld[i]),
            .rad_in   (s_rad[i]),
            .rem_in   (s_rem[i]),
            .root_in  (s_root[i]),
            .side_in  (s_side[i]),
            .out_vld  (s_vld[i+1]),
            .rad_out  (s_rad[i+1]),
            .rem_out  (s_rem[i+1]),
            .root_out (s_root[i+1]),
            .side_out (s_side[i+1])
        );
    end

    // -------------------------------------------------------- divider chain
    logic [T:0]            sr_energy;
    logic [ANGLE_BITS-1:0] sr_orient;
    logic                  zero_energy;
    logic                  saturate;

    always_comb
    begin
        {sr_energy, sr_orient} = s_side[RB];
        zero_energy = (sr_energy == '0);
        saturate    = (s_root[RB] >= sr_energy);
    end

    logic                  d_vld  [0:RATIO_BITS];
    logic [T:0]            d_den  [0:RATIO_BITS];
    logic [T:0]            d_rem  [0:RATIO_BITS];
    logic [RATIO_BITS-1:0] d_quo  [0:RATIO_BITS];
    logic [SIDED-1:0]      d_side [0:RATIO_BITS];

    assign d_vld[0]  = s_vld[RB];
    assign d_den[0]  = sr_energy;
    assign d_rem[0]  = (zero_energy || saturate) ? '0 : s_root[RB];
    assign d_quo[0]  = '0;
    assign d_side[0] = {sr_orient, zero_energy, saturate};

    for (genvar i = 0; i < RATIO_BITS; i++)
    begin : g_div
        stc_div_cell #(
            .DW     (T + 1),
            .QW     (RATIO_BITS),
            .SIDE_W (SIDED)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (d_vld[i]),
            .den_in   (d_den[i]),
            .rem_in   (d_rem[i]),
            .quo_in   (d_quo[i]),
            .side_in  (d_side[i]),
            .out_vld  (d_vld[i+1]),
            .den_out  (d_den[i+1]),
            .rem_out  (d_rem[i+1]),
            .quo_out  (d_quo[i+1]),
            .side_out (d_side[i+1])
        );
    end

    // ------------------------------------------------------- output register
    logic [ANGLE_BITS-1:0] dv_orient;
    logic                  dv_zero;
    logic                  dv_sat;
    logic [RATIO_BITS-1:0] coh_w;

    always_comb
    begin
        {dv_orient, dv_zero, dv_sat} = d_side[RATIO_BITS];
        if (dv_zero)
            coh_w = '0;
        else if (dv_sat)
            coh_w = '1;
        else
            coh_w = d_quo[RATIO_BITS];
    end

    logic                  out_vld_reg;
    logic [T:0]            out_energy_reg;
    logic [ANGLE_BITS-1:0] out_orient_reg;
    logic [RATIO_BITS-1:0] out_coh_reg;

    // advance the whole chain unless a result waits untaken
    assign en = !out_vld_reg || feature.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d_vld[RATIO_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_energy_reg <= d_den[RATIO_BITS];
            out_orient_reg <= dv_orient;
            out_coh_reg    <= coh_w;
        end
    end

    assign tensor.ready        = en;
    assign feature.valid       = out_vld_reg;
    assign feature.energy      = out_energy_reg;
    assign feature.orientation = out_orient_reg;
    assign feature.coherency   = out_coh_reg;

    // ------------------------------------------------------------ assertions
    a_stall_only_on_backpressure: assert property (
        @(posedge clk) disable iff (!rst_n)
        !tensor.ready |-> (out_vld_reg && !feature.ready)
    ) else $error("input stalled without output backpressure");

    a_zero_energy_zero_coherency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_energy_reg == '0)) |-> (out_coh_reg == '0)
    ) else $error("coherency nonzero for zero energy");

    a_chain_holds_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(d_quo[RATIO_BITS]) && $stable(s_root[RB]))
    ) else $error("chain moved while stalled");

endmodule

`default_nettype wire

[rtl/stc_cordic_cell.sv]
// ============================================================================
// stc_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift, registered.
// ============================================================================
`default_nettype none

module stc_cordic_cell #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 8
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   en,
    input  wire                                   in_vld,
    input  wire  signed [stc_pkg::CORDIC_W-1:0]   x_in,
    input  wire  signed [stc_pkg::CORDIC_W-1:0]   y_in,
    input  wire         [stc_pkg::TURN_W-1:0]     z_in,
    input  wire         [SIDE_W-1:0]              side_in,
    output logic                                  out_vld,
    output logic signed [stc_pkg::CORDIC_W-1:0]   x_out,
    output logic signed [stc_pkg::CORDIC_W-1:0]   y_out,
    output logic        [stc_pkg::TURN_W-1:0]     z_out,
    output logic        [SIDE_W-1:0]              side_out
);
    import stc_pkg::*;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic        [TURN_W-1:0]   z_next;
    logic        [TURN_W-1:0]   step_angle;

    // rotate toward the x axis
    always_comb
    begin
        xs         = x_in >>> SHIFT;
        ys         = y_in >>> SHIFT;
        step_angle = atan_turn(5'(SHIFT));
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + step_angle;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - step_angle;
        end
    end

    // hold valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (en)
            out_vld <= in_vld;
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out    <= x_next;
            y_out    <= y_next;
            z_out    <= z_next;
            side_out <= side_in;
        end
    end

endmodule

`default_nettype wire

[rtl/stc_sqrt_cell.sv]
// ============================================================================
// stc_sqrt_cell
// One digit of a restoring integer square root, registered.
// ============================================================================
`default_nettype none

module stc_sqrt_cell #(
    parameter int RB     = 25,
    parameter int RW     = 50,
    parameter int SIDE_W = 8
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                in_vld,
    input  wire  [RW-1:0]      rad_in,
    input  wire  [RB+1:0]      rem_in,
    input  wire  [RB-1:0]      root_in,
    input  wire  [SIDE_W-1:0]  side_in,
    output logic               out_vld,
    output logic [RW-1:0]      rad_out,
    output logic [RB+1:0]      rem_out,
    output logic [RB-1:0]      root_out,
    output logic [SIDE_W-1:0]  side_out
);
    logic [RB+3:0] rem_sh;
    logic [RB+3:0] trial;
    logic          take;
    logic [RB+1:0] rem_next;
    logic [RB-1:0] root_next;

    // bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh    = {rem_in, rad_in[RW-1:RW-2]};
        trial     = {2'b00, root_in, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? (RB+2)'(rem_sh - trial) : rem_sh[RB+1:0];
        root_next = {root_in[RB-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (en)
            out_vld <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_out  <= {rad_in[RW-3:0], 2'b00};
            rem_out  <= rem_next;
            root_out <= root_next;
            side_out <= side_in;
        end
    end

endmodule

`default_nettype wire

[rtl/stc_div_cell.sv]
// ============================================================================
// stc_div_cell
// One quotient bit of a restoring divider, registered.
// ============================================================================
`default_nettype none

module stc_div_cell #(
    parameter int DW     = 25,
    parameter int QW     = 16,
    parameter int SIDE_W = 8
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                in_vld,
    input  wire  [DW-1:0]      den_in,
    input  wire  [DW-1:0]      rem_in,
    input  wire  [QW-1:0]      quo_in,
    input  wire  [SIDE_W-1:0]  side_in,
    output logic               out_vld,
    output logic [DW-1:0]      den_out,
    output logic [DW-1:0]      rem_out,
    output logic [QW-1:0]      quo_out,
    output logic [SIDE_W-1:0]  side_out
);
    logic [DW:0] rem_sh;
    logic        take;

    // shift the remainder and subtract the divisor when it fits
    always_comb
    begin
        rem_sh = {rem_in, 1'b0};
        take   = (rem_sh >= {1'b0, den_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (en)
            out_vld <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_out  <= den_in;
            rem_out  <= take ? DW'(rem_sh - {1'b0, den_in}) : rem_sh[DW-1:0];
            quo_out  <= {quo_in[QW-2:0], take};
            side_out <= side_in;
        end
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for structure_tensor_features: drives pixel tensor
// terms over a valid/ready channel, predicts energy, orientation and
// coherency bit for bit and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import stc_pkg::*;

    localparam int TB = 24;
    localparam int AB = 16;
    localparam int RB = 16;

    typedef struct packed {
        logic [TB:0]   energy;
        logic [AB-1:0] orientation;
        logic [RB-1:0] coherency;
    } feature_t;

    logic clk;
    logic rst_n;

    stc_tensor_if  #(.TENSOR_BITS(TB)) tensor_ch ();
    stc_feature_if #(.TENSOR_BITS(TB), .ANGLE_BITS(AB), .RATIO_BITS(RB)) feature_ch ();

    structure_tensor_features #(.TENSOR_BITS(TB), .ANGLE_BITS(AB), .RATIO_BITS(RB)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tensor  (tensor_ch.sink),
        .feature (feature_ch.source)
    );

    feature_t pending_features[$];
    int       error_count;
    int       sent_count;
    int       got_count;
    bit       quiet_mode;
    bit       hold_off;

    // arctan(2^-i) in full-turn fractions
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // vectoring CORDIC on (x, y), angle in full-turn fractions
    function automatic logic [31:0] turn_of(longint x, longint y);
        logic [31:0] z;
        longint      xs;
        longint      ys;
        z = '0;
        if (y == 0)
            return (x < 0) ? HALF_TURN : 32'd0;
        x = x * (64'sd1 <<< (58 - TB));
        y = y * (64'sd1 <<< (58 - TB));
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic feature_t features_of(logic [TB-1:0] xx, logic [TB-1:0] yy,
                                             logic signed [TB-1:0] xy);
        feature_t      f;
        longint        d;
        longint        cxy;
        logic [127:0]  sum;
        logic [127:0]  t;
        logic [63:0]   root;
        logic [63:0]   rem;
        logic [63:0]   en;
        logic [32:0]   turn;
        logic [RB-1:0] coh;
        d    = longint'(xx) - longint'(yy);
        cxy  = 2 * longint'(xy);
        en   = 64'(xx) + 64'(yy);
        turn = {1'b0, turn_of(d, cxy)} + (33'd1 << (31 - AB));
        f.energy      = en[TB:0];
        f.orientation = turn[31 -: AB];
        sum  = 128'(d * d) + 128'(cxy * cxy);
        root = '0;
        for (int b = 43; b >= 0; b--)
        begin
            t = 128'(root | (64'd1 << b));
            if (t * t <= sum)
                root = t[63:0];
        end
        coh = '0;
        if (en != 0)
        begin
            if (root >= en)
                coh = '1;
            else
            begin
                rem = root;
                for (int i = 0; i < RB; i++)
                begin
                    rem = rem << 1;
                    coh = coh << 1;
                    if (rem >= en)
                    begin
                        rem = rem - en;
                        coh[0] = 1'b1;
                    end
                end
            end
        end
        f.coherency = coh;
        return f;
    endfunction

    // offer one pixel, wait for acceptance, queue its prediction
    task automatic send_pixel(logic [TB-1:0] xx, logic [TB-1:0] yy, logic [TB-1:0] xy);
        int gap;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            tensor_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tensor_ch.valid     <= 1'b1;
        tensor_ch.tensor_xx <= xx;
        tensor_ch.tensor_yy <= yy;
        tensor_ch.tensor_xy <= xy;
        pending_features.push_back(features_of(xx, yy, xy));
        @(posedge clk);
        while (!tensor_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic test_directed();
        logic [TB-1:0] mx;
        mx = '1;
        send_pixel('0, '0, '0);
        send_pixel(mx, mx, '0);
        send_pixel(mx, '0, '0);
        send_pixel('0, mx, '0);
        send_pixel('0, '0, 24'h7fffff);
        send_pixel('0, '0, 24'h800000);
        send_pixel(mx, mx, 24'h7fffff);
        send_pixel(mx, mx, 24'h800000);
        send_pixel('0, mx, 24'h800000);
        send_pixel(mx, '0, 24'h7fffff);
        send_pixel(24'd256, 24'd256, '0);
        send_pixel(24'd256, '0, '0);
        send_pixel('0, 24'd256, '0);
        send_pixel(24'd256, 24'd256, 24'h000100);
        send_pixel(24'd256, 24'd256, 24'hffff00);
        send_pixel(24'd1, '0, '0);
        send_pixel('0, 24'd1, 24'hffffff);
        send_pixel(24'd100, '0, 24'h400000);
        send_pixel(24'h123456, 24'h654321, 24'h0abcde);
        send_pixel(24'h5555aa, 24'haaaa55, 24'hf00f0f);
    endtask

    task automatic test_random(int count);
        logic [TB-1:0] xx;
        logic [TB-1:0] yy;
        logic [TB-1:0] xy;
        int            mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 4);
            xx = TB'($urandom());
            yy = TB'($urandom());
            xy = TB'($urandom());
            case (mode)
                0: xy = '0;
                1: yy = xx;
                2:
                begin
                    xx = TB'($urandom_range(0, 4095));
                    yy = TB'($urandom_range(0, 4095));
                    xy = TB'($urandom_range(0, 4095) - 2048);
                end
                default: ;
            endcase
            send_pixel(xx, yy, xy);
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(150);
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    // result sink: random ready, compare against oldest prediction
    initial
    begin
        feature_t want;
        int       stall;
        feature_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (feature_ch.valid && feature_ch.ready)
            begin
                got_count++;
                if (pending_features.size() == 0)
                begin
                    $error("result with no pixel pending");
                    error_count++;
                end
                else
                begin
                    want = pending_features.pop_front();
                    if (feature_ch.energy !== want.energy)
                    begin
                        $error("energy exp %0d got %0d", want.energy, feature_ch.energy);
                        error_count++;
                    end
                    if (feature_ch.orientation !== want.orientation)
                    begin
                        $error("orientation exp %0d got %0d", want.orientation,
                               feature_ch.orientation);
                        error_count++;
                    end
                    if (feature_ch.coherency !== want.coherency)
                    begin
                        $error("coherency exp %0d got %0d", want.coherency,
                               feature_ch.coherency);
                        error_count++;
                    end
                end
            end
            if (hold_off)
                feature_ch.ready <= 1'b0;
            else if (!quiet_mode && stall == 0 && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8);
                feature_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                feature_ch.ready <= (stall == 0);
            end
            else
                feature_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int drain;
        error_count = 0;
        sent_count  = 0;
        got_count   = 0;
        quiet_mode  = 1'b0;
        hold_off    = 1'b0;
        rst_n = 1'b0;
        tensor_ch.valid     = 1'b0;
        tensor_ch.tensor_xx = '0;
        tensor_ch.tensor_yy = '0;
        tensor_ch.tensor_xy = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        test_backpressure();
        quiet_mode = 1'b1;
        test_random(350);
        tensor_ch.valid <= 1'b0;
        drain = 0;
        while (pending_features.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);
        if (pending_features.size() != 0)
        begin
            $error("%0d results never arrived", pending_features.size());
            error_count++;
        end
        $display("covered %0d pixels, %0d results: axis, zero, extreme and random tensors,",
                 sent_count, got_count);
        $display("with idle bursts on both sides and one long output stall");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
